/* design/nibble_wildcard_pattern_scanner_assert.svh */
// ----------------------------------------------------------------------------
// nibble wildcard pattern scanner assertion macros
// clocked implication checks, same-cycle and next-cycle forms
// ----------------------------------------------------------------------------
`ifndef NIBBLE_WILDCARD_PATTERN_SCANNER_ASSERT_SVH
`define NIBBLE_WILDCARD_PATTERN_SCANNER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define NWPS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define NWPS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define NWPS_ASSERT_IMP(label, clk, rst, ante, cons, msg)

`define NWPS_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* design/nwps_pkg.sv */
// ----------------------------------------------------------------------------
// nwps_pkg
// shared types and constants of the nibble wildcard pattern scanner
// ----------------------------------------------------------------------------
`default_nettype none

package nwps_pkg;

   localparam int MAX_PATTERN_DEF  = 16;
   localparam int OFFSET_WIDTH_DEF = 32;

   localparam int DATA_WIDTH    = 8;
   localparam int RESULT_WIDTH  = 32;
   localparam int CSR_WIDTH     = 64;
   localparam int CSR_IDX_WIDTH = 2;
   localparam int PAT_WORD_WIDTH = 64;
   localparam int CARE_WIDTH    = 32;
   localparam int LEN_WIDTH     = 5;

   localparam logic [CARE_WIDTH-1:0] CARE_RESET = '1;
   localparam logic [LEN_WIDTH-1:0]  LEN_RESET  = 5'd1;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_PATTERN_LOW  = 2'd0,
      CSR_PATTERN_HIGH = 2'd1,
      CSR_CARE_MASK    = 2'd2,
      CSR_LENGTH       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] data_byte;
      logic                  last_byte;
   } req_type;

   typedef struct packed {
      logic                    found;
      logic [RESULT_WIDTH-1:0] match_offset;
   } rsp_type;

   typedef struct packed {
      logic [PAT_WORD_WIDTH-1:0] pattern_low_bytes;
      logic [PAT_WORD_WIDTH-1:0] pattern_high_bytes;
      logic [CARE_WIDTH-1:0]     nibble_care_mask;
      logic [LEN_WIDTH-1:0]      pattern_length;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic last_byte;
   } stage_type;

endpackage

`default_nettype wire

/* design/nibble_wildcard_pattern_scanner.sv */
// ----------------------------------------------------------------------------
// nibble_wildcard_pattern_scanner
// first-match byte signature scan with per-nibble wildcards
// ----------------------------------------------------------------------------
// usage
//   req channel: one byte of the scanned range per item, last_byte marks the end
//   rsp channel: at most one item per range; found with the start offset at the
//     first match, or not found with offset 0 on the last byte of a range
//   csr channel: pattern words, nibble care mask and length, written while idle;
//     csr_ready is always high, a write lands at the same edge
//   path: an accepted byte enters the window register, then the result register
//   throughput: one byte per cycle while req_stall is low, set by the window
//     register and a single parallel masked compare over all pattern lengths
//   reset: position, match state and output valid clear; care mask all ones,
//     pattern length one
//   rsp_stall holds the result register and the compare stage behind it;
//     req_stall rises only when the compare stage holds an item while the
//     result register is full and stalled
// ----------------------------------------------------------------------------
`default_nettype none

module nibble_wildcard_pattern_scanner #(
   parameter int MAX_PATTERN  = nwps_pkg::MAX_PATTERN_DEF,
   parameter int OFFSET_WIDTH = nwps_pkg::OFFSET_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire nwps_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output nwps_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [nwps_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [nwps_pkg::CSR_WIDTH-1:0]     csr_wdata
);

   nwps_pkg::cfg_type   cfg;
   nwps_pkg::stage_type stage;
   logic [MAX_PATTERN-1:0][nwps_pkg::DATA_WIDTH-1:0] window;
   logic [OFFSET_WIDTH-1:0] position;
   logic                    out_free;

   assign csr_ready = 1'b1;

   nwps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   nwps_window #(
      .MAX_PATTERN  (MAX_PATTERN),
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_free  (out_free),
      .stage     (stage),
      .window    (window),
      .position  (position)
   );

   nwps_match #(
      .MAX_PATTERN  (MAX_PATTERN),
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .stage     (stage),
      .window    (window),
      .position  (position),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* design/nwps_csr.sv */
// ----------------------------------------------------------------------------
// nwps_csr
// configuration registers: pattern words, nibble care mask, pattern length
// ----------------------------------------------------------------------------
`default_nettype none

module nwps_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   input  wire logic [nwps_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [nwps_pkg::CSR_WIDTH-1:0]    csr_wdata,
   output nwps_pkg::cfg_type                      cfg
);

   nwps_pkg::cfg_type cfg_ff;
   nwps_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (nwps_pkg::csr_index_type'(csr_index))
            nwps_pkg::CSR_PATTERN_LOW: begin
               cfg_in.pattern_low_bytes = csr_wdata;
            end
            nwps_pkg::CSR_PATTERN_HIGH: begin
               cfg_in.pattern_high_bytes = csr_wdata;
            end
            nwps_pkg::CSR_CARE_MASK: begin
               cfg_in.nibble_care_mask = csr_wdata[nwps_pkg::CARE_WIDTH-1:0];
            end
            nwps_pkg::CSR_LENGTH: begin
               cfg_in.pattern_length = csr_wdata[nwps_pkg::LEN_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low_bytes  <= '0;
         cfg_ff.pattern_high_bytes <= '0;
         cfg_ff.nibble_care_mask   <= nwps_pkg::CARE_RESET;
         cfg_ff.pattern_length     <= nwps_pkg::LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* design/nwps_window.sv */
// ----------------------------------------------------------------------------
// nwps_window
// input stage: byte window shift register and saturating byte position
// ----------------------------------------------------------------------------
`default_nettype none

module nwps_window #(
   parameter int MAX_PATTERN  = nwps_pkg::MAX_PATTERN_DEF,
   parameter int OFFSET_WIDTH = nwps_pkg::OFFSET_WIDTH_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_stall,
   input  wire nwps_pkg::req_type                         req_data,
   input  wire logic                                      out_free,
   output nwps_pkg::stage_type                            stage,
   output logic [MAX_PATTERN-1:0][nwps_pkg::DATA_WIDTH-1:0] window,
   output logic [OFFSET_WIDTH-1:0]                        position
);

   localparam logic [OFFSET_WIDTH-1:0] POS_MAX = '1;

   logic [MAX_PATTERN-1:0][nwps_pkg::DATA_WIDTH-1:0] window_ff;
   logic [MAX_PATTERN-1:0][nwps_pkg::DATA_WIDTH-1:0] window_in;
   logic [OFFSET_WIDTH-1:0] seen_ff;
   logic [OFFSET_WIDTH-1:0] seen_in;
   logic [OFFSET_WIDTH-1:0] pos_ff;
   logic [OFFSET_WIDTH-1:0] pos_in;
   logic                    valid_ff;
   logic                    valid_in;
   logic                    last_ff;
   logic                    last_in;
   logic                    accept;

   assign req_stall = valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      window_in = window_ff;
      seen_in   = seen_ff;
      pos_in    = pos_ff;
      last_in   = last_ff;
      valid_in  = accept || (valid_ff && !out_free);
      if (accept) begin
         for (int i = MAX_PATTERN - 1; i > 0; i--) begin
            window_in[i] = window_ff[i-1];
         end
         window_in[0] = req_data.data_byte;
         pos_in       = seen_ff;
         last_in      = req_data.last_byte;
         if (req_data.last_byte) begin
            seen_in = '0;
         end else if (seen_ff != POS_MAX) begin
            seen_in = seen_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         seen_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         seen_ff  <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      pos_ff    <= pos_in;
      last_ff   <= last_in;
   end

   assign stage.valid     = valid_ff;
   assign stage.last_byte = last_ff;
   assign window          = window_ff;
   assign position        = pos_ff;

endmodule

`default_nettype wire

/* design/nwps_match.sv */
// ----------------------------------------------------------------------------
// nwps_match
// masked window compare for every pattern length, match state, result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "nibble_wildcard_pattern_scanner_assert.svh"

module nwps_match #(
   parameter int MAX_PATTERN  = nwps_pkg::MAX_PATTERN_DEF,
   parameter int OFFSET_WIDTH = nwps_pkg::OFFSET_WIDTH_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire nwps_pkg::cfg_type                         cfg,
   input  wire nwps_pkg::stage_type                       stage,
   input  wire logic [MAX_PATTERN-1:0][nwps_pkg::DATA_WIDTH-1:0] window,
   input  wire logic [OFFSET_WIDTH-1:0]                   position,
   output logic                                           out_free,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output nwps_pkg::rsp_type                              rsp_data
);

   localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int WW = (OFFSET_WIDTH > nwps_pkg::RESULT_WIDTH) ?
                       OFFSET_WIDTH : nwps_pkg::RESULT_WIDTH;
   localparam int DW = nwps_pkg::DATA_WIDTH;

   logic [MAX_PATTERN-1:0][DW-1:0] pat_byte;
   logic [MAX_PATTERN-1:0][DW-1:0] care_byte;
   logic [MAX_PATTERN-1:0]         len_hit;
   logic [IW-1:0]                  len_m1;
   logic                           eligible;
   logic                           hit;
   logic                           hit_take;
   logic                           miss_emit;
   logic                           emit;
   logic                           b_go;
   logic [WW-1:0]                  diff;
   logic                           matched_ff;
   logic                           matched_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   nwps_pkg::rsp_type              rsp_data_ff;
   nwps_pkg::rsp_type              rsp_data_in;

   // pattern bytes and per-byte care masks
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (i < 8) begin
            pat_byte[i] = cfg.pattern_low_bytes[8*i +: 8];
         end else begin
            pat_byte[i] = cfg.pattern_high_bytes[8*(i-8) +: 8];
         end
         care_byte[i] = {{4{cfg.nibble_care_mask[2*i+1]}},
                         {4{cfg.nibble_care_mask[2*i]}}};
      end
   end

   // one match flag per candidate length, window index fixed per lane
   always_comb begin
      for (int l = 0; l < MAX_PATTERN; l++) begin
         len_hit[l] = 1'b1;
         for (int i = 0; i < MAX_PATTERN; i++) begin
            if (i <= l) begin
               if (((window[l-i] ^ pat_byte[i]) & care_byte[i]) != '0) begin
                  len_hit[l] = 1'b0;
               end
            end
         end
      end
   end

   // effective length minus one, zero acts as one, clamp to max
   always_comb begin
      if (cfg.pattern_length == '0) begin
         len_m1 = '0;
      end else if (cfg.pattern_length > nwps_pkg::LEN_WIDTH'(MAX_PATTERN)) begin
         len_m1 = IW'(MAX_PATTERN - 1);
      end else begin
         len_m1 = IW'(cfg.pattern_length - 1'b1);
      end
   end

   assign eligible  = position >= OFFSET_WIDTH'(len_m1);
   assign hit       = len_hit[len_m1];
   assign hit_take  = !matched_ff && eligible && hit;
   assign miss_emit = stage.last_byte && !matched_ff && !hit_take;
   assign emit      = hit_take || miss_emit;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign b_go      = stage.valid && out_free;
   assign diff      = WW'(position) - WW'(len_m1);

   always_comb begin
      matched_in   = matched_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (b_go) begin
         matched_in = stage.last_byte ? 1'b0 : (matched_ff || hit_take);
      end
      if (out_free) begin
         rsp_valid_in = b_go && emit;
         if (b_go && emit) begin
            rsp_data_in.found        = hit_take;
            rsp_data_in.match_offset = hit_take ? diff[nwps_pkg::RESULT_WIDTH-1:0] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matched_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         matched_ff   <= matched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `NWPS_ASSERT_IMP(a_miss_only_on_last, clock, reset, b_go && emit && !hit_take, stage.last_byte, "not-found result without last byte")
   `NWPS_ASSERT_NXT(a_match_sticks, clock, reset, b_go && hit_take && !stage.last_byte, matched_ff, "match state not set after a hit")
   `NWPS_ASSERT_IMP(a_silent_after_match, clock, reset, b_go && matched_ff, !emit, "result after match already reported")
   `NWPS_ASSERT_NXT(a_last_clears_match, clock, reset, b_go && stage.last_byte, !matched_ff, "match state kept across scans")

endmodule

`default_nettype wire
